// ===== hdl/flrm_pkg.sv =====
// Package for the four-lane running median filter.
// Holds default sizes shared by the top level and the lane and cell modules.
// No dependencies.
package flrm_pkg;

   // Number of independent lanes carried in one beat
   localparam int LANES = 4;

   // Default window length and sample width
   localparam int WINDOW_DEFAULT       = 10;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

endpackage : flrm_pkg

// ===== hdl/four_lane_running_median.sv =====
// Top level of the four-lane running median filter.
// Depends on flrm_pkg and flrm_lane.
//
// Usage:
//  - Input channel req_*: one beat carries one signed sample per lane. A beat
//    is taken at a clock edge with req_valid high and req_stall low.
//  - Result channel rsp_*: one beat per input beat, carrying the upper median
//    (rank WINDOW/2, ascending) of each lane's last WINDOW samples, the new
//    sample included.
//  - Latency: the result is valid the cycle after its input beat is taken.
//  - Throughput: one beat per cycle while the receiver does not stall. Each lane
//    is a row of WINDOW cells held in sorted order; one beat drops the oldest
//    sample and inserts the new one at once across the row.
//  - Reset (synchronous): all windows read as zeros, which join the ranking
//    until overwritten; the write slot returns to zero; no result is pending.
//  - When the receiver stalls, the pending result holds and req_stall rises,
//    so no input is taken until the result leaves.
module four_lane_running_median
   import flrm_pkg::*;
#(
   parameter int WINDOW       = WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_lane1,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_lane2,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_lane3,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_lane4,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median_lane1,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median_lane2,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median_lane3,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median_lane4
);

   localparam int SLOT_WIDTH = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic                           load;
   logic [SLOT_WIDTH-1:0]          wr_pos_ff, wr_pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample    [LANES];
   logic signed [SAMPLE_WIDTH-1:0] med_next  [LANES];
   logic signed [SAMPLE_WIDTH-1:0] median_ff [LANES];

   // Handshake: take a beat unless a result is held by the receiver
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign load      = req_valid && !req_stall;

   assign sample[0] = req_sample_lane1;
   assign sample[1] = req_sample_lane2;
   assign sample[2] = req_sample_lane3;
   assign sample[3] = req_sample_lane4;

   // Shared write slot, wraps after WINDOW-1
   always_comb begin
      wr_pos_in = wr_pos_ff;
      if (load) begin
         if (wr_pos_ff == SLOT_WIDTH'(WINDOW - 1)) begin
            wr_pos_in = '0;
         end else begin
            wr_pos_in = wr_pos_ff + 1'b1;
         end
      end
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Lanes and their result registers
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      flrm_lane #(
         .WINDOW      (WINDOW),
         .SAMPLE_WIDTH(SAMPLE_WIDTH),
         .SLOT_WIDTH  (SLOT_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .sample     (sample[l]),
         .wr_slot    (wr_pos_ff),
         .median_next(med_next[l])
      );

      always_ff @(posedge clock) begin
         if (load) begin
            median_ff[l] <= med_next[l];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_lane1 = median_ff[0];
   assign rsp_median_lane2 = median_ff[1];
   assign rsp_median_lane3 = median_ff[2];
   assign rsp_median_lane4 = median_ff[3];

endmodule : four_lane_running_median

// ===== hdl/flrm_cell.sv =====
// One cell of the sorted window chain: holds one sample and its window slot.
// Depends on flrm_pkg; instantiated by flrm_lane.
module flrm_cell
   import flrm_pkg::*;
#(
   parameter int WINDOW       = WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int SLOT_WIDTH   = $clog2(WINDOW),
   parameter int INDEX        = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic        [SLOT_WIDTH-1:0]   wr_slot,
   input  logic signed [SAMPLE_WIDTH-1:0] left_val,
   input  logic        [SLOT_WIDTH-1:0]   left_slot,
   input  logic                           left_rm_le,
   input  logic signed [SAMPLE_WIDTH-1:0] right_val,
   input  logic        [SLOT_WIDTH-1:0]   right_slot,
   output logic                           rm_le,
   output logic signed [SAMPLE_WIDTH-1:0] val,
   output logic        [SLOT_WIDTH-1:0]   slot,
   output logic signed [SAMPLE_WIDTH-1:0] val_next
);

   localparam bit FIRST = (INDEX == 0);
   localparam bit LAST  = (INDEX == WINDOW - 1);

   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic        [SLOT_WIDTH-1:0]   slot_ff, slot_in;

   logic signed [SAMPLE_WIDTH-1:0] own_c_val, prev_c_val;
   logic        [SLOT_WIDTH-1:0]   own_c_slot, prev_c_slot;
   logic                           own_c_ok, prev_c_ok;

   // The leaving entry sits at or below this cell
   assign rm_le = left_rm_le | (slot_ff == wr_slot);

   // Insert into the compacted list: keep, shift from the right, shift from
   // the left, or take the new sample.
   always_comb begin
      own_c_val   = rm_le ? right_val : val_ff;
      own_c_slot  = rm_le ? right_slot : slot_ff;
      prev_c_val  = left_rm_le ? val_ff : left_val;
      prev_c_slot = left_rm_le ? slot_ff : left_slot;
      own_c_ok    = !LAST && (own_c_val <= sample);
      prev_c_ok   = !FIRST && (prev_c_val > sample);
      if (own_c_ok) begin
         val_in  = own_c_val;
         slot_in = own_c_slot;
      end else if (prev_c_ok) begin
         val_in  = prev_c_val;
         slot_in = prev_c_slot;
      end else begin
         val_in  = sample;
         slot_in = wr_slot;
      end
   end

   // Reset leaves zeros, each cell owning its own window slot
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff  <= '0;
         slot_ff <= SLOT_WIDTH'(INDEX);
      end else if (load) begin
         val_ff  <= val_in;
         slot_ff <= slot_in;
      end
   end

   assign val      = val_ff;
   assign slot     = slot_ff;
   assign val_next = val_in;

endmodule : flrm_cell

// ===== hdl/flrm_lane.sv =====
// One lane: a row of WINDOW cells kept in ascending order of sample value.
// Depends on flrm_pkg and flrm_cell.
module flrm_lane
   import flrm_pkg::*;
#(
   parameter int WINDOW       = WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int SLOT_WIDTH   = $clog2(WINDOW)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic        [SLOT_WIDTH-1:0]   wr_slot,
   output logic signed [SAMPLE_WIDTH-1:0] median_next
);

   logic signed [SAMPLE_WIDTH-1:0] cell_val  [WINDOW];
   logic        [SLOT_WIDTH-1:0]   cell_slot [WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] cell_next [WINDOW];
   logic                           cell_rm   [WINDOW];

   // Chain of cells, each seeing its two neighbors
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] l_val, r_val;
      logic        [SLOT_WIDTH-1:0]   l_slot, r_slot;
      logic                           l_rm;

      if (i == 0) begin : g_head
         assign l_val  = '0;
         assign l_slot = '0;
         assign l_rm   = 1'b0;
      end else begin : g_link_l
         assign l_val  = cell_val[i-1];
         assign l_slot = cell_slot[i-1];
         assign l_rm   = cell_rm[i-1];
      end

      if (i == WINDOW - 1) begin : g_tail
         assign r_val  = '0;
         assign r_slot = '0;
      end else begin : g_link_r
         assign r_val  = cell_val[i+1];
         assign r_slot = cell_slot[i+1];
      end

      flrm_cell #(
         .WINDOW      (WINDOW),
         .SAMPLE_WIDTH(SAMPLE_WIDTH),
         .SLOT_WIDTH  (SLOT_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .sample    (sample),
         .wr_slot   (wr_slot),
         .left_val  (l_val),
         .left_slot (l_slot),
         .left_rm_le(l_rm),
         .right_val (r_val),
         .right_slot(r_slot),
         .rm_le     (cell_rm[i]),
         .val       (cell_val[i]),
         .slot      (cell_slot[i]),
         .val_next  (cell_next[i])
      );
   end

   // Upper median is the middle cell after the update
   assign median_next = cell_next[WINDOW/2];

endmodule : flrm_lane

// ===== hdl/flrm_checker.sv =====
// Port-level checks for the four-lane running median filter, with bind.
// Depends on flrm_pkg; attaches to four_lane_running_median.
module flrm_checker
   import flrm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_median_lane1
);

   // No result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every taken input beat yields a result beat in the next cycle
   a_beat_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("input beat without result");

   // Input stalls only while a result is held by the receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // A held result keeps its lane 1 payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_median_lane1)))
      else $error("stalled result changed");

endmodule : flrm_checker

bind four_lane_running_median flrm_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_flrm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_median_lane1(rsp_median_lane1)
);

// ===== bench/four_lane_running_median_tb.sv =====
// Self-checking bench for the four-lane running median filter.
// Depends on flrm_pkg and four_lane_running_median; drives random and directed beats,
// predicts each lane's upper median and checks every result beat in order.
`timescale 1ns / 1ps

module four_lane_running_median_tb;
   import flrm_pkg::*;

   localparam int WIN         = WINDOW_DEFAULT;
   localparam int SW          = SAMPLE_WIDTH_DEFAULT;
   localparam int IDLE_PCT    = 19;
   localparam int HOLD_CYCLES = 300;
   localparam int SMAX        = (1 << (SW - 1)) - 1;
   localparam int SMIN        = -(1 << (SW - 1));

   typedef logic signed [SW-1:0] sample_type;
   typedef sample_type [LANES-1:0] lane_set_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_sample_lane1 = '0;
   sample_type req_sample_lane2 = '0;
   sample_type req_sample_lane3 = '0;
   sample_type req_sample_lane4 = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_median_lane1;
   sample_type rsp_median_lane2;
   sample_type rsp_median_lane3;
   sample_type rsp_median_lane4;

   // predictor state: one circular window per lane and the shared slot
   sample_type   lane_window [LANES][WIN];
   int           write_slot = 0;
   lane_set_type median_q[$];
   int           drift_level [LANES];

   int   mismatch_count = 0;
   int   beats_sent = 0;
   int   medians_checked = 0;
   bit   idle_off = 1'b0;
   logic hold_active = 1'b0;
   event start_hold;

   four_lane_running_median #(.WINDOW(WIN), .SAMPLE_WIDTH(SW)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_lane1 (req_sample_lane1),
      .req_sample_lane2 (req_sample_lane2),
      .req_sample_lane3 (req_sample_lane3),
      .req_sample_lane4 (req_sample_lane4),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_lane1 (rsp_median_lane1),
      .rsp_median_lane2 (rsp_median_lane2),
      .rsp_median_lane3 (rsp_median_lane3),
      .rsp_median_lane4 (rsp_median_lane4)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // rank WIN/2 of one lane's window, ascending
   function automatic sample_type upper_median(int lane);
      int vals [WIN];
      int key;
      int j;
      for (int i = 0; i < WIN; i++) vals[i] = int'(lane_window[lane][i]);
      for (int i = 1; i < WIN; i++) begin
         key = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > key) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = key;
      end
      return sample_type'(vals[WIN / 2]);
   endfunction

   // write the beat into every lane, then rank each window
   function automatic lane_set_type predict_medians(lane_set_type s);
      lane_set_type m;
      for (int l = 0; l < LANES; l++) lane_window[l][write_slot] = s[l];
      for (int l = 0; l < LANES; l++) m[l] = upper_median(l);
      write_slot = (write_slot == WIN - 1) ? 0 : write_slot + 1;
      return m;
   endfunction

   function automatic lane_set_type make_set(int a, int b, int c, int d);
      lane_set_type s;
      s[0] = sample_type'(a);
      s[1] = sample_type'(b);
      s[2] = sample_type'(c);
      s[3] = sample_type'(d);
      return s;
   endfunction

   // mix of full-range, clustered (ties), extreme and slowly drifting samples
   function automatic lane_set_type random_beat();
      lane_set_type s;
      int v;
      for (int l = 0; l < LANES; l++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom);
            4, 5:       v = int'($urandom_range(0, 16)) - 8;
            6: begin
               case ($urandom_range(0, 3))
                  0:       v = SMAX;
                  1:       v = SMIN;
                  2:       v = 0;
                  default: v = -1;
               endcase
            end
            default: v = drift_level[l] + int'($urandom_range(0, 64)) - 32;
         endcase
         s[l] = sample_type'(v);
         drift_level[l] = int'(s[l]);
      end
      return s;
   endfunction

   task automatic flag_miss(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // offer one beat, wait for it to be taken, queue its expected medians
   task automatic send_beat(lane_set_type s);
      if (!idle_off) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_sample_lane1 <= s[0];
      req_sample_lane2 <= s[1];
      req_sample_lane3 <= s[2];
      req_sample_lane4 <= s[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      median_q.insert(median_q.size(), predict_medians(s));
      beats_sent++;
   endtask

   // sender goes quiet until every queued median has come back
   task automatic wait_for_medians();
      req_valid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, or a counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_active || (!idle_off && ($urandom_range(0, 99) < IDLE_PCT));
      end
   end

   always begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // result checker
   always @(posedge clock) begin : check_medians
      lane_set_type got;
      lane_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_median_lane4, rsp_median_lane3, rsp_median_lane2, rsp_median_lane1};
         if (median_q.size() == 0) begin
            flag_miss($sformatf("median beat with nothing expected: %0d %0d %0d %0d",
                                got[0], got[1], got[2], got[3]));
         end else begin
            want = median_q.pop_front();
            for (int l = 0; l < LANES; l++) begin
               if (got[l] !== want[l])
                  flag_miss($sformatf("beat %0d lane %0d: expected %0d, got %0d",
                                      medians_checked, l + 1, want[l], got[l]));
            end
         end
         medians_checked++;
      end
   end

   // first beats after reset: the cleared zeros still dominate the rank
   task automatic test_reset_zeros();
      send_beat(make_set(100, -100, 7, SMAX));
      send_beat(make_set(200, -200, 7, SMAX));
      send_beat(make_set(300, -300, -7, SMIN));
      send_beat(make_set(400, -400, -7, SMIN));
      send_beat(make_set(500, -500, 1, -1));
      send_beat(make_set(600, -600, 1, -1));
   endtask

   // full-scale values and alternating bit patterns in every lane
   task automatic test_field_extremes();
      send_beat(make_set(SMAX, SMIN, 0, -1));
      send_beat(make_set(SMIN, SMAX, -1, 0));
      send_beat(make_set('h5555, 'hAAAA, 'h5555, 'hAAAA));
      send_beat(make_set('hAAAA, 'h5555, 'hAAAA, 'h5555));
      send_beat(make_set(SMAX, SMAX, SMIN, SMIN));
      send_beat(make_set(SMIN, SMIN, SMAX, SMAX));
      send_beat(make_set(1, SMAX - 1, SMIN + 1, -2));
      send_beat(make_set(SMAX, SMIN, SMAX, SMIN));
   endtask

   // equal samples: a full window of one value, then one beat with a new value in three lanes
   task automatic test_equal_samples();
      for (int i = 0; i < 10; i++) send_beat(make_set(-3, 42, SMIN, 0));
      send_beat(make_set(-4, 43, SMAX, 0));
   endtask

   task automatic test_random_traffic(int count);
      for (int i = 0; i < count; i++) send_beat(random_beat());
   endtask

   // back-to-back beats with neither side idling
   task automatic test_quiet_stretch(int count);
      idle_off = 1'b1;
      for (int i = 0; i < count; i++) send_beat(random_beat());
      idle_off = 1'b0;
   endtask

   // receiver holds off while beats keep coming, so the input backs up
   task automatic test_stall_fill(int count);
      -> start_hold;
      for (int i = 0; i < count; i++) send_beat(random_beat());
   endtask

   // sender pauses mid-stream until the pipe is empty, then resumes
   task automatic test_drain_pause(int count);
      for (int i = 0; i < count; i++) send_beat(random_beat());
      wait_for_medians();
      for (int i = 0; i < count; i++) send_beat(random_beat());
   endtask

   initial begin
      for (int l = 0; l < LANES; l++) begin
         drift_level[l] = 0;
         for (int i = 0; i < WIN; i++) lane_window[l][i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_zeros();
      test_field_extremes();
      test_equal_samples();
      test_random_traffic(400);
      test_quiet_stretch(200);
      test_stall_fill(60);
      test_drain_pause(50);
      test_random_traffic(170);
      wait_for_medians();
      repeat (5) @(posedge clock);
      if (median_q.size() != 0)
         flag_miss($sformatf("%0d medians never arrived", median_q.size()));
      $display("Sent %0d beats, %0d-sample window, %0d lanes; %0d median beats checked,",
               beats_sent, WIN, LANES, medians_checked);
      $display("with random idling, a quiet stretch, a %0d-cycle hold-off and a drain pause.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("Timed out");
      $display("Some tests failed");
      $finish;
   end

endmodule : four_lane_running_median_tb
